// File: rtl/pcpfl_pkg.sv
// ============================================================================
// pcpfl_pkg
// Shared types and constants for the per-requester page free list allocator.
// ============================================================================
`default_nettype none

package pcpfl_pkg;

    // sizing
    localparam int NUM_REQUESTERS = 8;
    localparam int NUM_PAGES      = 32768;
    localparam int PAGE_SHIFT     = 12;

    localparam int ADDR_W    = 32;
    localparam int BASE_W    = ADDR_W + 1;
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    localparam int REQ_W     = $clog2(NUM_REQUESTERS);
    localparam int REQ_FLD_W = 3;
    localparam int STATUS_W  = 2;
    localparam int SRC_W     = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [BASE_W-1:0] PAGE_MASK = (BASE_W'(1) << PAGE_SHIFT) - BASE_W'(1);

    // operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_PAGE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

    // register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BOUND  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BOUND = 1'd1;
    localparam logic [BASE_W-1:0]    BASE_RESET     = 33'h0_8000_0000;
    localparam logic [ADDR_W-1:0]    HIGH_RESET     = 32'h8800_0000;

    typedef struct packed {
        logic                 func;
        logic [REQ_FLD_W-1:0] requester;
        logic [ADDR_W-1:0]    page_address;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   granted_address;
        logic [STATUS_W-1:0] status;
        logic [SRC_W-1:0]    source_list;
    } out_item_t;

    // one entry of the link memory
    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] page;
    } link_entry_t;

    // free address check result
    typedef struct packed {
        logic              ok;
        logic [PAGE_W-1:0] page;
    } addr_chk_t;

endpackage

`default_nettype wire

// File: rtl/per_cpu_page_free_list.sv
// ============================================================================
// per_cpu_page_free_list
// Page allocator with one LIFO free list per requester and stealing.
// ============================================================================
// One transaction at a time. A free goes through capture, then check and push
// into the link memory; an allocate that finds a page goes through capture,
// head select with link memory read, and head write-back from the registered
// read data; an allocate with every list empty goes through capture, then
// result. The registered link memory read is why an allocate that finds a
// page has the extra write-back step. The result sits in an output register, and a new
// transaction is taken while it waits, but the block holds in its final
// step if the previous result has not yet been taken. Link memory needs no
// clearing after reset: a link is only read for a page that was pushed.
`default_nettype none

module per_cpu_page_free_list (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration
    input  wire logic                            cfg_we,
    input  wire logic [pcpfl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pcpfl_pkg::ADDR_W-1:0]    cfg_wdata,
    // requests
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire pcpfl_pkg::in_item_t             s_data,
    // results
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output pcpfl_pkg::out_item_t                 m_data
);
    import pcpfl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LINK = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    in_item_t                  item_reg;
    logic [BASE_W-1:0]         base_reg;
    logic [ADDR_W-1:0]         high_reg;
    logic [NUM_REQUESTERS-1:0] head_valid_reg;
    logic [PAGE_W-1:0]         head_reg [NUM_REQUESTERS];
    logic [REQ_W-1:0]          lst_reg;
    logic [PAGE_W-1:0]         page_reg;
    logic                      m_valid_reg, m_valid_next;
    out_item_t                 m_data_reg;

    link_entry_t               link_mem [NUM_PAGES];
    link_entry_t               link_rd_reg;

    logic [REQ_W-1:0]          req;
    logic [REQ_W-1:0]          steal_lst;
    logic [REQ_W-1:0]          sel_lst;
    logic [REQ_W-1:0]          head_addr;
    logic [PAGE_W-1:0]         head_rd;
    logic                      any_valid;
    logic                      slot_free;
    logic                      is_free;
    logic                      free_done;
    logic                      empty_done;
    logic                      pop_start;
    logic                      pop_done;
    addr_chk_t                 chk;

    pcpfl_addr_check u_addr_check (
        .addr       (item_reg.page_address),
        .base       (base_reg),
        .high_bound (high_reg),
        .chk        (chk)
    );

    // list selection: own list first, else lowest non-empty
    always_comb begin
        req       = item_reg.requester[REQ_W-1:0];
        any_valid = |head_valid_reg;
        steal_lst = '0;
        for (int i = NUM_REQUESTERS - 1; i >= 0; i--) begin
            if (head_valid_reg[i]) begin
                steal_lst = REQ_W'(i);
            end
        end
        sel_lst   = head_valid_reg[req] ? req : steal_lst;
        is_free   = item_reg.func == FUNC_FREE;
        head_addr = is_free ? req : sel_lst;
        head_rd   = head_reg[head_addr];
    end

    // step control
    always_comb begin
        slot_free  = !m_valid_reg || m_ready;
        s_ready    = state_reg == S_IDLE;
        free_done  = (state_reg == S_EXEC) && is_free && slot_free;
        empty_done = (state_reg == S_EXEC) && !is_free && !any_valid && slot_free;
        pop_start  = (state_reg == S_EXEC) && !is_free && any_valid;
        pop_done   = (state_reg == S_LINK) && slot_free;

        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (pop_start) begin
                    state_next = S_LINK;
                end else if (free_done || empty_done) begin
                    state_next = S_IDLE;
                end
            end
            S_LINK: begin
                if (pop_done) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        m_valid_next = m_valid_reg && !m_ready;
        if (free_done || empty_done || pop_done) begin
            m_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            head_valid_reg <= '0;
            base_reg       <= BASE_RESET;
            high_reg       <= HIGH_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LOW_BOUND:
                        base_reg <= ({1'b0, cfg_wdata} + PAGE_MASK) & ~PAGE_MASK;
                    CFG_HIGH_BOUND:
                        high_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (free_done && chk.ok) begin
                head_valid_reg[req] <= 1'b1;
            end
            if (pop_done) begin
                head_valid_reg[lst_reg] <= link_rd_reg.valid;
            end
        end
    end

    // payload registers and list heads
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (pop_start) begin
            lst_reg  <= sel_lst;
            page_reg <= head_rd;
        end
        if (free_done && chk.ok) begin
            head_reg[req] <= chk.page;
        end
        if (pop_done) begin
            head_reg[lst_reg] <= link_rd_reg.page;
        end
        if (free_done) begin
            m_data_reg.granted_address <= '0;
            m_data_reg.status          <= chk.ok ? STATUS_OK : STATUS_BAD_FREE;
            m_data_reg.source_list     <= '0;
        end else if (empty_done) begin
            m_data_reg.granted_address <= '0;
            m_data_reg.status          <= STATUS_NO_PAGE;
            m_data_reg.source_list     <= '0;
        end else if (pop_done) begin
            m_data_reg.granted_address <= base_reg[ADDR_W-1:0]
                                        + (ADDR_W'(page_reg) << PAGE_SHIFT);
            m_data_reg.status          <= STATUS_OK;
            m_data_reg.source_list     <= SRC_W'(lst_reg);
        end
    end

    // link memory: push writes the old head, pop reads the successor
    always_ff @(posedge aclk) begin
        if (free_done && chk.ok) begin
            link_mem[chk.page] <= '{valid: head_valid_reg[req], page: head_rd};
        end
        if (pop_start) begin
            link_rd_reg <= link_mem[head_rd];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // an accepted transaction always goes to the execute step
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_EXEC)
        else $error("accepted transaction did not enter execute step");

    // write-back step only follows the execute step or itself
    a_link_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_LINK |-> $past(state_reg == S_EXEC || state_reg == S_LINK))
        else $error("link step entered out of order");

    // a pop only starts from a non-empty list
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_start |-> head_valid_reg[sel_lst])
        else $error("pop from an empty list");

    // a new result only appears after work on a transaction
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg != S_IDLE))
        else $error("result produced while idle");
`endif

endmodule

`default_nettype wire

// File: rtl/pcpfl_addr_check.sv
// ============================================================================
// pcpfl_addr_check
// Validates a free address against the managed window and yields its page.
// ============================================================================
`default_nettype none

module pcpfl_addr_check (
    input  wire logic [pcpfl_pkg::ADDR_W-1:0] addr,
    input  wire logic [pcpfl_pkg::BASE_W-1:0] base,
    input  wire logic [pcpfl_pkg::ADDR_W-1:0] high_bound,
    output pcpfl_pkg::addr_chk_t              chk
);
    import pcpfl_pkg::*;

    logic [BASE_W-1:0] addr_ext;
    logic [BASE_W-1:0] offset;
    logic [BASE_W-1:0] page_num;
    logic              aligned;
    logic              above_base;
    logic              below_high;
    logic              in_window;

    // offset from base and the window tests
    always_comb begin
        addr_ext   = {1'b0, addr};
        offset     = addr_ext - base;
        page_num   = offset >> PAGE_SHIFT;
        aligned    = (addr_ext & PAGE_MASK) == '0;
        above_base = addr_ext >= base;
        below_high = addr < high_bound;
        in_window  = page_num < BASE_W'(NUM_PAGES);
        chk.ok     = aligned && above_base && below_high && in_window;
        chk.page   = page_num[PAGE_W-1:0];
    end

endmodule

`default_nettype wire

// File: tb/sv/page_grant_sb_pkg.sv
// ============================================================================
// page_grant_sb_pkg
// Scoreboard for the per-requester page free list allocator. It keeps its own
// copy of the bounds, the list heads and the page links, works out the grant
// for every request the block accepts, and compares each result the block
// hands back against the oldest outstanding grant.
// ============================================================================
package page_grant_sb_pkg;

    import pcpfl_pkg::*;

    class page_grant_scoreboard;

        // bounds as last written
        logic [ADDR_W-1:0] low_bound;
        logic [ADDR_W-1:0] high_bound;

        // free list state, pages named by index from the base
        bit                head_valid [NUM_REQUESTERS];
        logic [PAGE_W-1:0] head_page  [NUM_REQUESTERS];
        bit                link_valid [NUM_PAGES];
        logic [PAGE_W-1:0] link_page  [NUM_PAGES];

        out_item_t   expected_grants[$];
        int unsigned mismatch_count;

        function new();
            low_bound      = ADDR_W'(BASE_RESET);
            high_bound     = HIGH_RESET;
            mismatch_count = 0;
            foreach (head_valid[i]) begin
                head_valid[i] = 1'b0;
                head_page[i]  = '0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
            case (idx)
                CFG_LOW_BOUND:  low_bound  = value;
                CFG_HIGH_BOUND: high_bound = value;
                default: ;
            endcase
        endfunction

        // low bound rounded up to a page, may reach past 32 bits
        function logic [BASE_W-1:0] page_base();
            return ({1'b0, low_bound} + PAGE_MASK) & ~PAGE_MASK;
        endfunction

        // pop the head of one list, returns 0 when the list is empty
        function bit take_head(int lst, output logic [PAGE_W-1:0] pg);
            if (!head_valid[lst])
                return 1'b0;
            pg              = head_page[lst];
            head_valid[lst] = link_valid[pg];
            head_page[lst]  = link_valid[pg] ? link_page[pg] : '0;
            return 1'b1;
        endfunction

        function out_item_t predict_grant(in_item_t item);
            out_item_t         res;
            logic [BASE_W-1:0] base;
            logic [BASE_W-1:0] addr;
            logic [BASE_W-1:0] offset;
            logic [PAGE_W-1:0] pg;
            int                req;
            bit                got;
            base       = page_base();
            addr       = {1'b0, item.page_address};
            offset     = addr - base;
            req        = int'(item.requester) % NUM_REQUESTERS;
            res        = '0;
            res.status = STATUS_OK;
            if (item.func == FUNC_FREE) begin
                // aligned, inside the bounds and inside the link window
                if (addr[PAGE_SHIFT-1:0] == '0 && addr >= base &&
                    addr < {1'b0, high_bound} && (offset >> PAGE_SHIFT) < NUM_PAGES) begin
                    pg              = offset[PAGE_SHIFT +: PAGE_W];
                    link_valid[pg]  = head_valid[req];
                    link_page[pg]   = head_page[req];
                    head_valid[req] = 1'b1;
                    head_page[req]  = pg;
                end else begin
                    res.status = STATUS_BAD_FREE;
                end
            end else begin
                // own list first, then steal from the lowest non-empty list
                got = take_head(req, pg);
                if (got)
                    res.source_list = SRC_W'(req);
                for (int i = 0; i < NUM_REQUESTERS; i++) begin
                    if (!got) begin
                        got = take_head(i, pg);
                        if (got)
                            res.source_list = SRC_W'(i);
                    end
                end
                if (got)
                    res.granted_address = ADDR_W'(base + (BASE_W'(pg) << PAGE_SHIFT));
                else
                    res.status = STATUS_NO_PAGE;
            end
            return res;
        endfunction

        function void note_request(in_item_t item);
            expected_grants.push_back(predict_grant(item));
        endfunction

        function void check_grant(out_item_t got);
            out_item_t want;
            if (expected_grants.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"grant check: result with no request pending: ",
                              "addr %h status %0d list %0d"},
                             got.granted_address, got.status, got.source_list);
                return;
            end
            want = expected_grants.pop_front();
            if (got.granted_address !== want.granted_address || got.status !== want.status ||
                got.source_list !== want.source_list) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"grant check: expected addr %h status %0d list %0d, ",
                              "got addr %h status %0d list %0d"},
                             want.granted_address, want.status, want.source_list,
                             got.granted_address, got.status, got.source_list);
            end
        endfunction

    endclass

endpackage

// File: tb/sv/tb.sv
// ============================================================================
// tb
// Testbench for per_cpu_page_free_list. A directed run covers empty lists,
// bound and alignment rejects, stealing and double frees; random phases then
// sweep several bound settings, extremes included, with random idling on both
// channels and one phase without any.
// ============================================================================
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pcpfl_pkg::*;
    import page_grant_sb_pkg::*;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_LOW_BOUND;
    logic [ADDR_W-1:0]    cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;

    bit                   idling    = 1'b1;
    page_grant_scoreboard grants    = new();

    per_cpu_page_free_list u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // result side: check each transaction, stall now and then
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            grants.check_grant(m_data);
        m_ready <= !(idling && $urandom_range(0, 99) < 7);
    end

    // present one request and hold it until accepted
    task automatic send_item(input in_item_t item);
        if (idling && $urandom_range(0, 99) < 7) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 7);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        grants.note_request(item);
    endtask

    task automatic send_op(input logic func, input int req, input logic [ADDR_W-1:0] addr);
        in_item_t item;
        item.func         = func;
        item.requester    = REQ_FLD_W'(req);
        item.page_address = addr;
        send_item(item);
    endtask

    // wait for every outstanding grant, then let the block finish its write-back
    task automatic settle_block();
        s_valid <= 1'b0;
        while (grants.expected_grants.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_bounds(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LOW_BOUND;
        cfg_wdata <= lo;
        @(posedge aclk);
        grants.set_reg(CFG_LOW_BOUND, lo);
        cfg_index <= CFG_HIGH_BOUND;
        cfg_wdata <= hi;
        @(posedge aclk);
        grants.set_reg(CFG_HIGH_BOUND, hi);
        cfg_we <= 1'b0;
    endtask

    // mostly well-formed frees of a few low pages, some edge and junk addresses
    function automatic in_item_t random_item(int unsigned free_pct, int unsigned span);
        in_item_t          item;
        logic [BASE_W-1:0] base;
        int unsigned       pick;
        base              = grants.page_base();
        item.requester    = REQ_FLD_W'($urandom_range(0, NUM_REQUESTERS - 1));
        item.page_address = $urandom();
        item.func         = ($urandom_range(0, 99) < free_pct) ? FUNC_FREE : FUNC_ALLOC;
        if (item.func == FUNC_FREE) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                item.page_address =
                    ADDR_W'(base + (BASE_W'($urandom_range(0, span - 1)) << PAGE_SHIFT));
            else if (pick < 84)
                item.page_address = ADDR_W'(base + (BASE_W'(NUM_PAGES - 1) << PAGE_SHIFT));
            else if (pick < 88)
                item.page_address = ADDR_W'(base + (BASE_W'(NUM_PAGES) << PAGE_SHIFT));
            else if (pick < 90)
                item.page_address = grants.high_bound;
            else if (pick < 92)
                item.page_address = grants.high_bound & ~ADDR_W'(PAGE_MASK);
            else if (pick < 96)
                item.page_address = ADDR_W'(base + (BASE_W'($urandom_range(0, span - 1))
                                    << PAGE_SHIFT) + BASE_W'($urandom_range(1, 4095)));
        end
        return item;
    endfunction

    initial begin
        int unsigned       free_pct;
        int unsigned       span;
        logic [ADDR_W-1:0] lo;
        free_pct = 50;
        span     = 16;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed run on the reset bounds
        send_op(FUNC_ALLOC, 0, 32'hFFFF_FFFF);   // every list empty
        send_op(FUNC_FREE,  3, 32'h8000_0000);   // first page
        send_op(FUNC_FREE,  3, 32'h87FF_F000);   // last page of the window
        send_op(FUNC_FREE,  3, 32'h8800_0000);   // at the high bound
        send_op(FUNC_FREE,  3, 32'h7FFF_F000);   // below the base
        send_op(FUNC_FREE,  3, 32'h8000_0800);   // not page aligned
        send_op(FUNC_FREE,  3, 32'hFFFF_FFFF);
        send_op(FUNC_FREE,  3, 32'h0000_0000);
        send_op(FUNC_ALLOC, 3, 32'h0000_0000);   // own list
        send_op(FUNC_ALLOC, 5, 32'hFFFF_FFFF);   // steal from list 3
        send_op(FUNC_ALLOC, 7, 32'h0000_0000);   // empty again
        send_op(FUNC_FREE,  7, 32'h8000_1000);
        send_op(FUNC_FREE,  7, 32'h8000_1000);   // double free links the page to itself
        send_op(FUNC_FREE,  0, 32'h8000_2000);
        send_op(FUNC_ALLOC, 1, 32'h0000_0000);   // steal from the lowest list
        send_op(FUNC_ALLOC, 7, 32'h0000_0000);
        send_op(FUNC_ALLOC, 7, 32'h0000_0000);   // same page once more
        send_op(FUNC_FREE,  2, 32'h8000_1000);   // relink the page onto list 2
        send_op(FUNC_ALLOC, 7, 32'h0000_0000);
        send_op(FUNC_ALLOC, 2, 32'h0000_0000);
        send_op(FUNC_ALLOC, 4, 32'hFFFF_FFFF);   // all lists drained

        // random phases over several bound settings
        for (int p = 0; p < 6; p++) begin
            settle_block();
            case (p)
                0: begin
                    free_pct = 55;
                    span     = 48;
                end
                1: begin
                    // seven pages only, lists run dry often
                    write_bounds(32'h0000_0001, 32'h0000_8000);
                    free_pct = 50;
                    span     = 9;
                end
                2: begin
                    write_bounds(32'h0000_0000, 32'hFFFF_FFFF);
                    free_pct = 45;
                    span     = 40;
                    idling   = 1'b0;
                end
                3: begin
                    // base rounds past 32 bits, every free is rejected
                    write_bounds(32'hFFFF_FFFF, 32'h0000_0000);
                    free_pct = 30;
                    span     = 16;
                    idling   = 1'b1;
                end
                4: begin
                    write_bounds(32'hFFFF_0000, 32'hFFFF_FFFF);
                    free_pct = 50;
                    span     = 17;
                end
                default: begin
                    lo = $urandom();
                    write_bounds(lo, lo + $urandom_range(32'h1000, 32'h4_0000));
                    free_pct = 50;
                    span     = 64;
                end
            endcase
            repeat (255) send_item(random_item(free_pct, span));
        end

        settle_block();
        if (grants.mismatch_count == 0)
            $display("per_cpu_page_free_list: match");
        else
            $display("per_cpu_page_free_list: mismatch");
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("per_cpu_page_free_list: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
rtl/pcpfl_pkg.sv
rtl/pcpfl_addr_check.sv
rtl/per_cpu_page_free_list.sv
tb/sv/page_grant_sb_pkg.sv
tb/sv/tb.sv
